/* src/ssg_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and control structs for the Sobol sequence generator.
// Used by every module under src except ssg_ram; depends on nothing.
package ssg_pkg;

   localparam int BITS        = 30;
   localparam int MAX_DIM_DEF = 64;
   localparam int OUT_LIMIT   = 64;
   localparam int MAX_DEG     = 16;

   localparam int DIM_W  = 6;
   localparam int DEG_W  = 5;
   localparam int POLY_W = 15;
   localparam int REQ_W  = 2;
   localparam int ST_W   = 3;
   localparam int CFG_W  = 7;
   localparam int CNT_W  = BITS + 1;
   localparam int BIT_W  = $clog2(BITS);
   localparam int J_W    = $clog2(BITS + 1);
   localparam int WSEL_W = $clog2(MAX_DEG);
   localparam int SEED_W = BITS + 8;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;

   localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RESTART = 2'd1;
   localparam logic [REQ_W-1:0] REQ_NEXT    = 2'd2;

   localparam logic [ST_W-1:0] ST_POINT     = 3'd0;
   localparam logic [ST_W-1:0] ST_LOAD_DONE = 3'd1;
   localparam logic [ST_W-1:0] ST_RESTARTED = 3'd2;
   localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd3;
   localparam logic [ST_W-1:0] ST_BAD_REQ   = 3'd4;

   typedef struct packed {
      logic start;
      logic step;
   } dir_ctl_type;

   typedef struct packed {
      logic [BITS-1:0] value;
      logic            last;
   } dir_sts_type;

   typedef struct packed {
      logic clear;
      logic wr_en;
   } pt_ctl_type;

endpackage

/* src/ssg_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module ssg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ssg_dir_unit.sv */
`timescale 1ns / 1ps
// Direction number builder: one recurrence step per cycle while ctl.step is high, over a
// window of the last MAX_DEG values. Depends on ssg_pkg.
module ssg_dir_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  ssg_pkg::dir_ctl_type        ctl,
   input  logic [ssg_pkg::DIM_W-1:0]   dim_in,
   input  logic [ssg_pkg::DEG_W-1:0]   deg_in,
   input  logic [ssg_pkg::POLY_W-1:0]  poly_in,
   output ssg_pkg::dir_sts_type        sts
);

   logic [ssg_pkg::SEED_W-1:0] seed_ff, seed_in;
   logic [ssg_pkg::DEG_W-1:0]  deg_ff, deg_in_r;
   logic [ssg_pkg::MAX_DEG-1:1] coef_ff, coef_in;
   logic [ssg_pkg::J_W-1:0]    j_ff, j_in;
   logic [ssg_pkg::BITS-1:0]   win_ff [ssg_pkg::MAX_DEG];
   logic [ssg_pkg::BITS-1:0]   value;
   logic [ssg_pkg::BITS-1:0]   tap;
   logic [ssg_pkg::BITS-1:0]   acc;
   logic [ssg_pkg::WSEL_W-1:0] tap_sel;
   logic [7:0]                 seed8;

   always_comb begin
      logic [ssg_pkg::DEG_W-1:0] idx;
      idx = '0;
      coef_in = '0;
      for (int l = 1; l < ssg_pkg::MAX_DEG; l++) begin
         idx = deg_in - ssg_pkg::DEG_W'(1) - ssg_pkg::DEG_W'(l);
         if (ssg_pkg::DEG_W'(l) < deg_in) begin
            coef_in[l] = poly_in[idx[ssg_pkg::WSEL_W-1:0]];
         end
      end
   end

   assign seed8    = 8'd3 + {1'b0, dim_in, 1'b0};
   assign tap_sel  = ssg_pkg::WSEL_W'(deg_ff - ssg_pkg::DEG_W'(1));
   assign tap      = win_ff[tap_sel];

   always_comb begin
      acc = tap ^ (tap >> deg_ff);
      for (int l = 1; l < ssg_pkg::MAX_DEG; l++) begin
         if (coef_ff[l]) begin
            acc = acc ^ win_ff[l-1];
         end
      end
   end

   assign value = (ssg_pkg::DEG_W'(j_ff) <= deg_ff) ? seed_ff[ssg_pkg::BITS-1:0] : acc;

   always_comb begin
      seed_in  = seed_ff;
      deg_in_r = deg_ff;
      j_in     = j_ff;
      if (ctl.start) begin
         seed_in  = ssg_pkg::SEED_W'(seed8) << (ssg_pkg::BITS - 1);
         deg_in_r = deg_in;
         j_in     = ssg_pkg::J_W'(1);
      end else if (ctl.step) begin
         seed_in  = seed_ff >> 1;
         j_in     = j_ff + ssg_pkg::J_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0;
      end else begin
         j_ff <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
      deg_ff  <= deg_in_r;
      if (ctl.start) begin
         coef_ff <= coef_in;
      end
      if (ctl.step) begin
         win_ff[0] <= value;
         for (int i = 1; i < ssg_pkg::MAX_DEG; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   assign sts.value = value;
   assign sts.last  = (j_ff == ssg_pkg::J_W'(ssg_pkg::BITS));

endmodule

/* src/ssg_point_store.sv */
`timescale 1ns / 1ps
// Per-dimension point state: RAM plus one valid bit per entry, so that a clear
// resets every entry together. Depends on ssg_pkg and ssg_ram.
module ssg_point_store #(
   parameter int MAX_DIM = ssg_pkg::MAX_DIM_DEF,
   localparam int PAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ssg_pkg::pt_ctl_type        ctl,
   input  logic [PAW-1:0]             addr,
   input  logic [ssg_pkg::BITS-1:0]   wr_data,
   output logic [ssg_pkg::BITS-1:0]   rd_data
);

   logic [MAX_DIM-1:0]       valid_ff;
   logic                     rd_valid_ff;
   logic [ssg_pkg::BITS-1:0] ram_q;

   ssg_ram #(
      .WIDTH (ssg_pkg::BITS),
      .DEPTH (MAX_DIM)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_addr (addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[addr];
         if (ctl.clear) begin
            valid_ff <= '0;
         end else if (ctl.wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? ram_q : '0;

endmodule

/* src/sobol_sequence_generator.sv */
`timescale 1ns / 1ps
// Sobol sequence generator top level: sequencer, counter, output word register.
// Depends on ssg_pkg, ssg_ram, ssg_dir_unit and ssg_point_store.
// Sequence: a load word is accepted in S_IDLE, then S_LOAD builds its BITS direction
// numbers and stores them in the table RAM (one recurrence step per cycle), and S_ONE
// posts the result. A restart squares and cubes dim_count (two registered multiplies).
// A next word is accepted in S_IDLE, then each dimension in use goes through S_NRD
// (RAM read) and S_NXOR (XOR and write-back); dimensions go one after another over
// the single table RAM read port. A rejected or exhausted request goes from S_IDLE
// to S_ONE; S_ONE and S_NXOR wait for a free result side. The block takes one request
// word at a time and accepts a new one while its last result word still waits in the output register.
module sobol_sequence_generator #(
   parameter int MAX_DIM = ssg_pkg::MAX_DIM_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // dim_index [5:0], poly_degree [10:6], poly_bits [25:11], zero fill
   input  logic [ssg_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type [1:0]
   input  logic [ssg_pkg::REQ_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // point_value [29:0], out_dim [35:30], zero fill
   output logic [ssg_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   // status [2:0]
   output logic [ssg_pkg::ST_W-1:0]         rsp_tuser,
   input  logic                             csr_we,
   input  logic [ssg_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int AW  = $clog2(MAX_DIM * ssg_pkg::BITS);
   localparam int PAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_CUBE = 3'd2;
   localparam logic [2:0] S_ONE  = 3'd3;
   localparam logic [2:0] S_NRD  = 3'd4;
   localparam logic [2:0] S_NXOR = 3'd5;

   logic [2:0]                        state_ff, state_in;
   logic [ssg_pkg::CFG_W-1:0]         dim_count_ff, dim_count_in;
   logic [ssg_pkg::CNT_W-1:0]         counter_ff, counter_in;
   logic [AW-1:0]                     addr_ff, addr_in;
   logic [ssg_pkg::DIM_W-1:0]         k_ff, k_in;
   logic [2*ssg_pkg::CFG_W-1:0]       sq_ff, sq_in;
   logic [ssg_pkg::ST_W-1:0]          one_status_ff, one_status_in;
   logic [ssg_pkg::DIM_W-1:0]         one_dim_ff, one_dim_in;
   logic [ssg_pkg::DIM_W-1:0]         dim_ff, dim_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ssg_pkg::BITS-1:0]          rsp_value_ff, rsp_value_in;
   logic [ssg_pkg::DIM_W-1:0]         rsp_dim_ff, rsp_dim_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [ssg_pkg::ST_W-1:0]          rsp_status_ff, rsp_status_in;

   logic [ssg_pkg::DIM_W-1:0]         req_dim;
   logic [ssg_pkg::DEG_W-1:0]         req_deg;
   logic [ssg_pkg::POLY_W-1:0]        req_poly;
   logic                              req_acc;
   logic                              out_free;
   logic                              load_bad;
   logic                              count_bad;
   logic                              exhausted;
   logic [ssg_pkg::BITS-1:0]          low;
   logic [ssg_pkg::BITS-1:0]          lowest_zero;
   logic [ssg_pkg::BIT_W-1:0]         bit_sel;
   logic [3*ssg_pkg::CFG_W-1:0]       cube;
   logic [ssg_pkg::BITS-1:0]          new_point;

   ssg_pkg::dir_ctl_type              dir_ctl;
   ssg_pkg::dir_sts_type              dir_sts;
   ssg_pkg::pt_ctl_type               pt_ctl;
   logic                              dir_wr;
   logic [ssg_pkg::BITS-1:0]          dir_q;
   logic [ssg_pkg::BITS-1:0]          pt_q;

   assign req_dim  = req_tdata[5:0];
   assign req_deg  = req_tdata[10:6];
   assign req_poly = req_tdata[25:11];

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign load_bad  = (32'(req_dim) >= MAX_DIM) || (req_deg == '0) ||
                      (32'(req_deg) > ssg_pkg::MAX_DEG) || (32'(req_deg) > ssg_pkg::BITS);
   assign count_bad = (dim_count_ff == '0) || (32'(dim_count_ff) > MAX_DIM) ||
                      (32'(dim_count_ff) > ssg_pkg::OUT_LIMIT);

   assign low         = counter_ff[ssg_pkg::BITS-1:0];
   assign exhausted   = &low;
   assign lowest_zero = (low + ssg_pkg::BITS'(1)) & ~low;

   always_comb begin
      bit_sel = '0;
      for (int i = 0; i < ssg_pkg::BITS; i++) begin
         if (lowest_zero[i]) begin
            bit_sel = bit_sel | ssg_pkg::BIT_W'(i);
         end
      end
   end

   assign cube      = (3*ssg_pkg::CFG_W)'(sq_ff) * (3*ssg_pkg::CFG_W)'(dim_count_ff);
   assign new_point = pt_q ^ dir_q;

   ssg_dir_unit u_dir (
      .clock   (clock),
      .reset   (reset),
      .ctl     (dir_ctl),
      .dim_in  (req_dim),
      .deg_in  (req_deg),
      .poly_in (req_poly),
      .sts     (dir_sts)
   );

   ssg_ram #(
      .WIDTH (ssg_pkg::BITS),
      .DEPTH (MAX_DIM * ssg_pkg::BITS)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_wr),
      .wr_addr (addr_ff),
      .wr_data (dir_sts.value),
      .rd_addr (addr_ff),
      .rd_data (dir_q)
   );

   ssg_point_store #(
      .MAX_DIM (MAX_DIM)
   ) u_point (
      .clock   (clock),
      .reset   (reset),
      .ctl     (pt_ctl),
      .addr    (PAW'(k_ff)),
      .wr_data (new_point),
      .rd_data (pt_q)
   );

   always_comb begin
      state_in      = state_ff;
      dim_count_in  = csr_we ? csr_wdata : dim_count_ff;
      counter_in    = counter_ff;
      addr_in       = addr_ff;
      k_in          = k_ff;
      sq_in         = sq_ff;
      one_status_in = one_status_ff;
      one_dim_in    = one_dim_ff;
      dim_in        = dim_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_dim_in    = rsp_dim_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      dir_ctl       = '0;
      pt_ctl        = '0;
      dir_wr        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               one_dim_in = '0;
               unique case (req_tuser)
                  ssg_pkg::REQ_LOAD: begin
                     if (load_bad) begin
                        one_status_in = ssg_pkg::ST_BAD_REQ;
                        state_in      = S_ONE;
                     end else begin
                        dir_ctl.start = 1'b1;
                        addr_in       = AW'(32'(req_dim) * ssg_pkg::BITS);
                        dim_in        = req_dim;
                        state_in      = S_LOAD;
                     end
                  end
                  ssg_pkg::REQ_RESTART: begin
                     pt_ctl.clear = 1'b1;
                     sq_in        = (2*ssg_pkg::CFG_W)'(dim_count_ff) *
                                    (2*ssg_pkg::CFG_W)'(dim_count_ff);
                     state_in     = S_CUBE;
                  end
                  ssg_pkg::REQ_NEXT: begin
                     if (count_bad) begin
                        one_status_in = ssg_pkg::ST_BAD_REQ;
                        state_in      = S_ONE;
                     end else if (exhausted) begin
                        one_status_in = ssg_pkg::ST_EXHAUSTED;
                        state_in      = S_ONE;
                     end else begin
                        addr_in  = AW'(bit_sel);
                        k_in     = '0;
                        state_in = S_NRD;
                     end
                  end
                  default: begin
                     one_status_in = ssg_pkg::ST_BAD_REQ;
                     state_in      = S_ONE;
                  end
               endcase
            end
         end
         S_LOAD: begin
            dir_ctl.step = 1'b1;
            dir_wr       = 1'b1;
            if (dir_sts.last) begin
               one_status_in = ssg_pkg::ST_LOAD_DONE;
               one_dim_in    = dim_ff;
               state_in      = S_ONE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_CUBE: begin
            counter_in    = ssg_pkg::CNT_W'(cube);
            one_status_in = ssg_pkg::ST_RESTARTED;
            state_in      = S_ONE;
         end
         S_ONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_dim_in    = one_dim_ff;
               rsp_last_in   = 1'b1;
               rsp_status_in = one_status_ff;
               state_in      = S_IDLE;
            end
         end
         S_NRD: begin
            state_in = S_NXOR;
         end
         S_NXOR: begin
            if (out_free) begin
               pt_ctl.wr_en  = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = new_point;
               rsp_dim_in    = k_ff;
               rsp_status_in = ssg_pkg::ST_POINT;
               if ((ssg_pkg::CFG_W'(k_ff) + ssg_pkg::CFG_W'(1)) == dim_count_ff) begin
                  rsp_last_in = 1'b1;
                  counter_in  = counter_ff + ssg_pkg::CNT_W'(1);
                  state_in    = S_IDLE;
               end else begin
                  rsp_last_in = 1'b0;
                  k_in        = k_ff + ssg_pkg::DIM_W'(1);
                  addr_in     = addr_ff + AW'(ssg_pkg::BITS);
                  state_in    = S_NRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dim_count_ff <= ssg_pkg::CFG_W'(1);
         counter_ff   <= ssg_pkg::CNT_W'(1);
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         dim_count_ff <= dim_count_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      sq_ff         <= sq_in;
      one_status_ff <= one_status_in;
      one_dim_ff    <= one_dim_in;
      dim_ff        <= dim_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_dim_ff    <= rsp_dim_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_dim_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* src/ssg_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the Sobol sequence generator, bound to the top level.
// Depends on ssg_pkg and sobol_sequence_generator.
module ssg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ssg_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast,
   input logic [ssg_pkg::ST_W-1:0]         rsp_tuser
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request side ready right after accepting a word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ssg_pkg::ST_POINT)) |->
         (rsp_tlast && (rsp_tdata[ssg_pkg::BITS-1:0] == '0)))
      else $error("non-point result without last or with a value");

   a_mid_point_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |-> !req_tready)
      else $error("request side ready in the middle of a point");

endmodule

bind sobol_sequence_generator ssg_checker u_ssg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

/* tb/sv/tb_sobol_sequence_generator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sobol_sequence_generator: a directed opening, then random phases
// of loads, restarts, next-point and invalid requests, checked against a cycle-free predictor.
// Depends on ssg_pkg and the sobol_sequence_generator RTL.
module tb_sobol_sequence_generator;
   import ssg_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_LEN    = 400;
   localparam int TAIL_CYCLES = 2 * OUT_LIMIT + 72;

   typedef struct packed {
      logic [BITS-1:0]  value;
      logic [DIM_W-1:0] dim;
      logic             last;
      logic [ST_W-1:0]  status;
   } rsp_word_type;

   class sobol_tracker;
      logic [BITS-1:0]  dir_tab [MAX_DIM_DEF*BITS];
      logic [BITS-1:0]  pts [MAX_DIM_DEF];
      logic [CNT_W-1:0] counter;
      logic [CFG_W-1:0] dims;
      rsp_word_type     pending_words [$];
      int mismatches = 0;
      int items_seen = 0;
      int words_seen = 0;
      int n_point    = 0;
      int n_load     = 0;
      int n_restart  = 0;
      int n_reject   = 0;
      int n_exhaust  = 0;

      function new();
         foreach (dir_tab[i]) dir_tab[i] = '0;
         foreach (pts[i]) pts[i] = '0;
         counter = CNT_W'(1);
         dims    = CFG_W'(1);
      endfunction

      function void set_dims(logic [CFG_W-1:0] v);
         dims = v;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function void expect_word(logic [BITS-1:0] value, int dim, logic last,
                                logic [ST_W-1:0] st);
         rsp_word_type w;
         w.value  = value;
         w.dim    = DIM_W'(dim);
         w.last   = last;
         w.status = st;
         pending_words.push_back(w);
      endfunction

      function void build_directions(logic [DIM_W-1:0] d, int dg, logic [POLY_W-1:0] poly);
         logic [BITS-1:0]   v [BITS+1];
         logic [BITS-1:0]   x;
         logic [BITS-1:0]   seed;
         logic [POLY_W-1:0] p;
         int j;
         int l;
         v[0] = '0;
         seed = BITS'(3 + 2 * int'(d));
         for (j = 1; j <= dg; j++)
            v[j] = (seed & ((BITS'(1) << j) - BITS'(1))) << (BITS - j);
         for (j = dg + 1; j <= BITS; j++) begin
            x = v[j - dg];
            x = x ^ (x >> dg);
            p = poly;
            for (l = dg - 1; l >= 1; l--) begin
               if (p[0])
                  x = x ^ v[j - l];
               p = p >> 1;
            end
            v[j] = x;
         end
         for (j = 1; j <= BITS; j++)
            dir_tab[int'(d) * BITS + j - 1] = v[j];
      endfunction

      function void advance_point();
         int n;
         int b;
         logic [BITS-1:0] low;
         n   = int'(dims);
         low = counter[BITS-1:0];
         if (n < 1 || n > MAX_DIM_DEF || n > OUT_LIMIT) begin
            expect_word('0, 0, 1'b1, ST_BAD_REQ);
         end else if (&low) begin
            expect_word('0, 0, 1'b1, ST_EXHAUSTED);
         end else begin
            b = 0;
            while (b < BITS && low[b])
               b++;
            for (int k = 0; k < n; k++) begin
               pts[k] = pts[k] ^ dir_tab[k * BITS + b];
               expect_word(pts[k], k, k == n - 1, ST_POINT);
            end
            counter = counter + CNT_W'(1);
         end
      endfunction

      function void take_request(logic [REQ_W-1:0] kind, logic [DIM_W-1:0] d,
                                 logic [DEG_W-1:0] deg, logic [POLY_W-1:0] poly);
         int unsigned c;
         items_seen++;
         case (kind)
            REQ_LOAD: begin
               if (deg < 1 || deg > MAX_DEG || deg > BITS) begin
                  expect_word('0, 0, 1'b1, ST_BAD_REQ);
               end else begin
                  build_directions(d, int'(deg), poly);
                  expect_word('0, int'(d), 1'b1, ST_LOAD_DONE);
               end
            end
            REQ_RESTART: begin
               foreach (pts[i]) pts[i] = '0;
               c = 32'(dims);
               counter = CNT_W'(c * c * c);
               expect_word('0, 0, 1'b1, ST_RESTARTED);
            end
            REQ_NEXT: advance_point();
            default: expect_word('0, 0, 1'b1, ST_BAD_REQ);
         endcase
      endfunction

      function void check_word(logic [BITS-1:0] value, logic [DIM_W-1:0] dim, logic last,
                               logic [ST_W-1:0] st);
         rsp_word_type want;
         words_seen++;
         if (pending_words.size() == 0) begin
            $error("unexpected result word: point_value %0h out_dim %0d last %0b status %0d",
                   value, dim, last, st);
            mismatches++;
            return;
         end
         want = pending_words.pop_front();
         if (value !== want.value) begin
            $error("point_value: expected %0h, got %0h", want.value, value);
            mismatches++;
         end
         if (dim !== want.dim) begin
            $error("out_dim: expected %0d, got %0d", want.dim, dim);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            mismatches++;
         end
         if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            mismatches++;
         end
         case (want.status)
            ST_POINT:     n_point++;
            ST_LOAD_DONE: n_load++;
            ST_RESTARTED: n_restart++;
            ST_EXHAUSTED: n_exhaust++;
            default:      n_reject++;
         endcase
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_W-1:0]       req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic [ST_W-1:0]        rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CFG_W-1:0]       csr_wdata  = '0;

   sobol_tracker trk;
   bit  loaded [MAX_DIM_DEF];
   int  cur_dims      = 1;
   int  send_idle_pct = 0;
   int  rcv_stall_pct = 0;
   int  hold_reqs     = 0;
   int  hold_seen     = 0;
   int  hold_left     = 0;
   int  cycle_count   = 0;

   sobol_sequence_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sobol_sequence_generator verification failed");
         $finish;
      end
   end

   // result side: check accepted words, then choose the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         trk.check_word(rsp_tdata[BITS-1:0], rsp_tdata[BITS+DIM_W-1:BITS], rsp_tlast,
                        rsp_tuser);
      if (hold_reqs != hold_seen) begin
         hold_seen  <= hold_reqs;
         hold_left  <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   task automatic send_word(logic [REQ_W-1:0] kind, logic [DIM_W-1:0] d,
                            logic [DEG_W-1:0] deg, logic [POLY_W-1:0] poly);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, poly, deg, d};
      do @(posedge clock); while (!req_tready);
      trk.take_request(kind, d, deg, poly);
   endtask

   task automatic load_dim(logic [DIM_W-1:0] d, logic [DEG_W-1:0] deg,
                           logic [POLY_W-1:0] poly);
      loaded[d] = 1'b1;
      send_word(REQ_LOAD, d, deg, poly);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (trk.pending() != 0)
         @(posedge clock);
   endtask

   task automatic set_dim_count(int v);
      drain();
      // let a rejected word finish inside the block
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CFG_W'(v);
      @(posedge clock);
      trk.set_dims(CFG_W'(v));
      csr_we   <= 1'b0;
      cur_dims = v;
   endtask

   task automatic random_word();
      int pick;
      int miss;
      pick = $urandom_range(99);
      miss = -1;
      if (cur_dims >= 1 && cur_dims <= MAX_DIM_DEF)
         for (int k = cur_dims - 1; k >= 0; k--)
            if (!loaded[k])
               miss = k;
      if (pick < 55) begin
         if (miss >= 0)
            load_dim(DIM_W'(miss), DEG_W'($urandom_range(MAX_DEG, 1)), POLY_W'($urandom));
         else
            send_word(REQ_NEXT, DIM_W'($urandom), DEG_W'($urandom), POLY_W'($urandom));
      end else if (pick < 78) begin
         load_dim(DIM_W'($urandom), DEG_W'($urandom_range(MAX_DEG, 1)), POLY_W'($urandom));
      end else if (pick < 86) begin
         send_word(REQ_RESTART, DIM_W'($urandom), DEG_W'($urandom), POLY_W'($urandom));
      end else if (pick < 93) begin
         send_word(REQ_LOAD, DIM_W'($urandom),
                   $urandom_range(1) ? DEG_W'(0) : DEG_W'($urandom_range(31, 17)),
                   POLY_W'($urandom));
      end else begin
         send_word(REQ_UNKNOWN, DIM_W'($urandom), DEG_W'($urandom), POLY_W'($urandom));
      end
   endtask

   task automatic run_phase(int dims_val, int send_pct, int rcv_pct, int count);
      set_dim_count(dims_val);
      send_idle_pct = send_pct;
      rcv_stall_pct = rcv_pct;
      repeat (count) random_word();
   endtask

   initial begin
      trk = new();
      foreach (loaded[i]) loaded[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_dim_count(1);
      load_dim(6'd0, 5'd1, 15'h0000);
      load_dim(6'd63, 5'd16, 15'h7FFF);
      load_dim(6'd1, 5'd16, 15'h0000);
      load_dim(6'd2, 5'd7, 15'h002A);
      send_word(REQ_LOAD, 6'd5, 5'd0, 15'h7FFF);
      send_word(REQ_LOAD, 6'd63, 5'd17, 15'h0000);
      send_word(REQ_LOAD, 6'd63, 5'd31, 15'h7FFF);
      send_word(REQ_UNKNOWN, 6'h3F, 5'h1F, 15'h7FFF);
      repeat (3) send_word(REQ_NEXT, 6'd0, 5'd0, 15'h0000);
      send_word(REQ_RESTART, 6'd0, 5'd0, 15'h0000);
      send_word(REQ_NEXT, 6'h3F, 5'h1F, 15'h7FFF);
      set_dim_count(0);
      send_word(REQ_NEXT, 6'd0, 5'd0, 15'h0000);
      send_word(REQ_RESTART, 6'd0, 5'd0, 15'h0000);
      set_dim_count(1);
      send_word(REQ_NEXT, 6'd0, 5'd0, 15'h0000);
      set_dim_count(127);
      send_word(REQ_NEXT, 6'd0, 5'd0, 15'h0000);
      send_word(REQ_RESTART, 6'd0, 5'd0, 15'h0000);
      set_dim_count(3);
      repeat (2) send_word(REQ_NEXT, 6'd0, 5'd0, 15'h0000);

      run_phase(8, 0, 0, 70);
      run_phase(64, 88, 0, 80);
      run_phase($urandom_range(64, 1), 0, 88, 80);

      // hold the result side off while requests keep coming
      set_dim_count(16);
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      hold_reqs <= hold_reqs + 1;
      repeat (40) random_word();

      run_phase(2, 22, 22, 50);
      run_phase($urandom_range(1) ? 0 : $urandom_range(127, 65), 22, 22, 30);
      run_phase(1, 22, 22, 50);
      run_phase($urandom_range(64, 1), 0, 0, 50);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d request words and %0d result words: %0d coordinates, %0d loads,",
               trk.items_seen, trk.words_seen, trk.n_point, trk.n_load);
      $display("  %0d restarts, %0d rejections, %0d exhausted, dim_count from 0 to 127",
               trk.n_restart, trk.n_reject, trk.n_exhaust);
      if (trk.mismatches == 0 && trk.pending() == 0)
         $display("sobol_sequence_generator verification clean");
      else
         $display("sobol_sequence_generator verification failed");
      $finish;
   end

endmodule
